@@ rtl/bffa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg
// shared constants, codes and controller/datapath interface types for the
// bitmap first-free allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int WORD_BITS   = 32;
    localparam int WORD_SHIFT  = $clog2(WORD_BITS);
    localparam int WORD_COUNT  = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORD_COUNT);
    localparam int ENTRY_W     = 11;
    localparam int STATUS_W    = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [ENTRY_W-1:0] CNT_MAX = ENTRY_W'(MAX_ENTRIES);

    typedef enum logic [STATUS_W-1:0] {
        STS_OK           = 2'd0,
        STS_FULL         = 2'd1,
        STS_RANGE        = 2'd2,
        STS_ALREADY_FREE = 2'd3
    } status_t;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_NUMBER_BASE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_CHK
    } state_t;

    typedef struct packed {
        logic    clear_step;
        logic    start_req;
        logic    scan_step;
        logic    alloc_commit;
        logic    free_read;
        logic    free_commit;
        logic    post;
        status_t post_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic cnt_zero;
        logic hit;
        logic scan_fail;
        logic range_bad;
        logic bit_set;
    } dp_status_t;

endpackage : bffa_pkg
`default_nettype wire

@@ rtl/bitmap_first_free_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_core
// usage bitmap allocator: allocate lowest free entry or free a given entry
//
//   channel   handshake                        payload
//   request   start & !busy                    op, entry_number
//   result    done (one cycle, no stall)       status, allocated_number, free_count
//   config    psel & penable & pwrite & pready paddr, pwdata, prdata
//
// after reset a clearing pass writes the 32 bitmap words, with busy high until it ends
// allocate scans one 32-bit word per cycle and strobes the result after the first word
//   with a free entry or at the last word; zero entry count reports full, no read
// free is a one-word read-modify-write; out of range it ends before the read
// one request at a time; busy drops with the strobe; results are never held off
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          op,
    input  wire logic [bffa_pkg::ENTRY_W-1:0]  entry_number,
    output logic                               done,
    output logic      [bffa_pkg::STATUS_W-1:0] status,
    output logic      [bffa_pkg::ENTRY_W-1:0]  allocated_number,
    output logic      [bffa_pkg::ENTRY_W-1:0]  free_count,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bffa_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bffa_pkg::APB_DW-1:0]   pwdata,
    output logic      [bffa_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import bffa_pkg::*;

    logic [ENTRY_W-1:0] entry_count;
    logic               number_base;
    ctrl_cmd_t          cmd;
    dp_status_t         dp_sts;

    bffa_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .entry_count (entry_count),
        .number_base (number_base)
    );

    bffa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .dp_sts (dp_sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    bffa_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .entry_number     (entry_number),
        .entry_count      (entry_count),
        .number_base      (number_base),
        .dp_sts           (dp_sts),
        .done             (done),
        .status           (status),
        .allocated_number (allocated_number),
        .free_count       (free_count)
    );

endmodule : bitmap_first_free_allocator_core
`default_nettype wire

@@ rtl/bffa_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_regs
// apb configuration registers: entry count and number base
// ----------------------------------------------------------------------------
module bffa_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bffa_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bffa_pkg::APB_DW-1:0]   pwdata,
    output logic      [bffa_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output logic      [bffa_pkg::ENTRY_W-1:0]  entry_count,
    output logic                               number_base
);
    import bffa_pkg::*;

    logic [ENTRY_W-1:0] entry_count_reg;
    logic [ENTRY_W-1:0] entry_count_next;
    logic               number_base_reg;
    logic               number_base_next;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb
    begin
        entry_count_next = entry_count_reg;
        number_base_next = number_base_reg;
        if (wr_en)
        begin
            if (reg_sel == REG_ENTRY_COUNT)
                entry_count_next = pwdata[ENTRY_W-1:0];
            else
                number_base_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= CNT_MAX;
            number_base_reg <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            number_base_reg <= number_base_next;
        end
    end

    always_comb
    begin
        if (reg_sel == REG_ENTRY_COUNT)
            prdata = APB_DW'(entry_count_reg);
        else
            prdata = APB_DW'(number_base_reg);
    end

    assign entry_count = entry_count_reg;
    assign number_base = number_base_reg;

endmodule : bffa_regs
`default_nettype wire

@@ rtl/bffa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_ctrl
// sequencer for clearing, allocate scan and free read-modify-write
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    op,
    input  wire bffa_pkg::dp_status_t    dp_sts,
    output bffa_pkg::ctrl_cmd_t          cmd,
    output logic                         busy
);
    import bffa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (dp_sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = op ? ST_FREE_RD : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (dp_sts.cnt_zero || dp_sts.scan_fail || dp_sts.hit)
                    state_next = ST_IDLE;
            end
            ST_FREE_RD:
            begin
                if (dp_sts.range_bad)
                    state_next = ST_IDLE;
                else
                    state_next = ST_FREE_CHK;
            end
            ST_FREE_CHK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.post_status = STS_OK;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.start_req = start;
            end
            ST_SCAN:
            begin
                if (dp_sts.cnt_zero || dp_sts.scan_fail)
                begin
                    cmd.post        = 1'b1;
                    cmd.post_status = STS_FULL;
                end
                else if (dp_sts.hit)
                begin
                    cmd.alloc_commit = 1'b1;
                    cmd.post         = 1'b1;
                    cmd.post_status  = STS_OK;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            ST_FREE_RD:
            begin
                if (dp_sts.range_bad)
                begin
                    cmd.post        = 1'b1;
                    cmd.post_status = STS_RANGE;
                end
                else
                    cmd.free_read = 1'b1;
            end
            ST_FREE_CHK:
            begin
                cmd.post = 1'b1;
                if (dp_sts.bit_set)
                begin
                    cmd.free_commit = 1'b1;
                    cmd.post_status = STS_OK;
                end
                else
                    cmd.post_status = STS_ALREADY_FREE;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule : bffa_ctrl
`default_nettype wire

@@ rtl/bffa_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_dp
// bitmap word memory, first-free word search, usage counter and result regs
// ----------------------------------------------------------------------------
module bffa_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bffa_pkg::ctrl_cmd_t           cmd,
    input  wire logic      [bffa_pkg::ENTRY_W-1:0]  entry_number,
    input  wire logic      [bffa_pkg::ENTRY_W-1:0]  entry_count,
    input  wire logic                          number_base,
    output bffa_pkg::dp_status_t               dp_sts,
    output logic                               done,
    output logic      [bffa_pkg::STATUS_W-1:0] status,
    output logic      [bffa_pkg::ENTRY_W-1:0]  allocated_number,
    output logic      [bffa_pkg::ENTRY_W-1:0]  free_count
);
    import bffa_pkg::*;

    logic [WORD_BITS-1:0] mem [WORD_COUNT];

    logic [WORD_BITS-1:0]  rd_data_reg;
    logic [WORD_AW-1:0]    rd_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic [WORD_AW-1:0]    wr_addr;
    logic [WORD_BITS-1:0]  wr_data;

    logic [WORD_AW-1:0]    clr_idx_reg;
    logic [WORD_AW:0]      scan_idx_reg;
    logic [WORD_AW-1:0]    chk_idx_reg;
    logic                  chk_valid_reg;
    logic [ENTRY_W-1:0]    num_reg;
    logic [ENTRY_W-1:0]    used_count_reg;
    logic [ENTRY_W-1:0]    used_next;

    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ENTRY_W-1:0]    alloc_reg;
    logic [ENTRY_W-1:0]    free_cnt_reg;

    logic [ENTRY_W-1:0]    cnt;
    logic [ENTRY_W-1:0]    cnt_m1;
    logic [WORD_AW-1:0]    last_word;
    logic [WORD_SHIFT-1:0] last_bit;
    logic [WORD_BITS-1:0]  word_mask;
    logic [WORD_BITS-1:0]  free_bits;
    logic [WORD_BITS-1:0]  lowest;
    logic [WORD_SHIFT-1:0] bit_idx;
    logic [ENTRY_W-1:0]    granted;
    logic [ENTRY_W-1:0]    free_pos;
    logic [WORD_AW-1:0]    free_word;
    logic [WORD_SHIFT-1:0] free_bit;
    logic [WORD_BITS-1:0]  free_onehot;

    // effective entry count and last word of the scan
    assign cnt       = (entry_count > CNT_MAX) ? CNT_MAX : entry_count;
    assign cnt_m1    = cnt - ENTRY_W'(1);
    assign last_word = cnt_m1[WORD_SHIFT+WORD_AW-1:WORD_SHIFT];
    assign last_bit  = cnt_m1[WORD_SHIFT-1:0];

    always_comb
    begin
        if (chk_idx_reg == last_word)
            word_mask = {WORD_BITS{1'b1}} >> (WORD_SHIFT'(WORD_BITS - 1) - last_bit);
        else
            word_mask = {WORD_BITS{1'b1}};
    end

    assign free_bits = ~rd_data_reg & word_mask;
    assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

    always_comb
    begin
        bit_idx = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (lowest[j])
                bit_idx = bit_idx | WORD_SHIFT'(j);
        end
    end

    assign granted = ENTRY_W'({chk_idx_reg, bit_idx}) + ENTRY_W'(number_base);

    // free position decode
    assign free_pos    = num_reg - ENTRY_W'(number_base);
    assign free_word   = free_pos[WORD_SHIFT+WORD_AW-1:WORD_SHIFT];
    assign free_bit    = free_pos[WORD_SHIFT-1:0];
    assign free_onehot = WORD_BITS'(1) << free_bit;

    assign dp_sts.clear_last = (clr_idx_reg == WORD_AW'(WORD_COUNT - 1));
    assign dp_sts.cnt_zero   = (cnt == '0);
    assign dp_sts.hit        = chk_valid_reg && (free_bits != '0);
    assign dp_sts.scan_fail  = chk_valid_reg && (free_bits == '0) && (chk_idx_reg == last_word);
    assign dp_sts.range_bad  = (num_reg < ENTRY_W'(number_base)) || (free_pos >= cnt);
    assign dp_sts.bit_set    = |(rd_data_reg & free_onehot);

    // memory ports
    assign rd_en   = cmd.scan_step || cmd.free_read;
    assign rd_addr = cmd.free_read ? free_word : scan_idx_reg[WORD_AW-1:0];
    assign wr_en   = cmd.clear_step || cmd.alloc_commit || cmd.free_commit;

    always_comb
    begin
        wr_addr = clr_idx_reg;
        wr_data = '0;
        if (cmd.alloc_commit)
        begin
            wr_addr = chk_idx_reg;
            wr_data = rd_data_reg | lowest;
        end
        else if (cmd.free_commit)
        begin
            wr_addr = free_word;
            wr_data = rd_data_reg & ~free_onehot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        used_next = used_count_reg;
        if (cmd.alloc_commit)
            used_next = used_count_reg + ENTRY_W'(1);
        else if (cmd.free_commit && (used_count_reg != '0))
            used_next = used_count_reg - ENTRY_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            scan_idx_reg   <= '0;
            chk_idx_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            used_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            used_count_reg <= used_next;
            done_reg       <= cmd.post;
            if (cmd.clear_step)
                clr_idx_reg <= clr_idx_reg + WORD_AW'(1);
            if (cmd.start_req)
            begin
                scan_idx_reg  <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg  <= scan_idx_reg + (WORD_AW+1)'(1);
                chk_idx_reg   <= scan_idx_reg[WORD_AW-1:0];
                chk_valid_reg <= (scan_idx_reg <= {1'b0, last_word});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_req)
            num_reg <= entry_number;
        if (cmd.post)
        begin
            status_reg   <= cmd.post_status;
            alloc_reg    <= cmd.alloc_commit ? granted : '0;
            free_cnt_reg <= (cnt > used_next) ? (cnt - used_next) : '0;
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign allocated_number = alloc_reg;
    assign free_count       = free_cnt_reg;

`ifndef SYNTHESIS
    a_commit_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> (chk_valid_reg && (free_bits != '0)))
        else $error("allocate commit without a free bit in the checked word");

    a_free_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_commit |-> $past(cmd.free_read))
        else $error("free commit without a preceding word read");

    a_used_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |=> (used_count_reg == $past(used_count_reg) + ENTRY_W'(1)))
        else $error("used count not incremented on allocate");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");
`endif

endmodule : bffa_dp
`default_nettype wire
